FILE: hdl/tpkl_pkg.sv
// ----------------------------------------------------------------------------
// tpkl_pkg
// Shared types, keypad geometry, key codes and register indexes for the
// touch PIN keypad lock.
// ----------------------------------------------------------------------------
package tpkl_pkg;

    localparam int DEF_MAX_DIGITS = 7;

    localparam int COORD_W  = 10;
    localparam int SPAN_W   = 12;   // origin plus largest key offset and size
    localparam int CODE_W   = 4;
    localparam int COUNT_W  = 3;
    localparam int PIN_W    = 28;
    localparam int PLEN_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 28;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SPAN_W-1:0]  span_t;
    typedef logic [CODE_W-1:0]  key_code_t;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_DIGITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd3;

    // Register reset values: PIN "1234", four digits
    localparam logic [PIN_W-1:0]   RST_PIN_DIGITS = 28'h0004321;
    localparam logic [PLEN_W-1:0]  RST_PIN_LENGTH = 3'd4;
    localparam coord_t             RST_ORIGIN_X   = 10'd245;
    localparam coord_t             RST_ORIGIN_Y   = 10'd100;

    // Key codes
    localparam key_code_t KEY_CLR = 4'd10;
    localparam key_code_t KEY_OK  = 4'd11;

    // Keypad geometry
    localparam int KEY_ROWS = 4;
    localparam int KEY_COLS = 3;
    localparam span_t KEY_WIDTH  = 12'd90;
    localparam span_t KEY_HEIGHT = 12'd65;
    // Column offsets: pitch 110, last column pulled left by 15
    localparam span_t COL_OFFSET [KEY_COLS] = '{12'd0, 12'd110, 12'd205};
    // Row offsets: pitch 85 plus 0, 10, 25, 40
    localparam span_t ROW_OFFSET [KEY_ROWS] = '{12'd0, 12'd95, 12'd195, 12'd295};

    // Row-major key legend: 1 2 3 / 4 5 6 / 7 8 9 / CLR 0 OK
    localparam key_code_t KEY_LEGEND [KEY_ROWS*KEY_COLS] = '{
        4'd1, 4'd2, 4'd3,
        4'd4, 4'd5, 4'd6,
        4'd7, 4'd8, 4'd9,
        KEY_CLR, 4'd0, KEY_OK
    };

    typedef struct packed {
        logic      hit;
        key_code_t code;
    } key_t;

    typedef struct packed {
        logic               key_hit;
        key_code_t          key_code;
        logic [COUNT_W-1:0] entered_count;
        logic               pin_accepted;
        logic               pin_rejected;
    } result_t;

endpackage

FILE: hdl/tpkl_sample_if.sv
// ----------------------------------------------------------------------------
// tpkl_sample_if
// Touch poll sample channel: valid/ready handshake with sample payload.
// ----------------------------------------------------------------------------
interface tpkl_sample_if import tpkl_pkg::*;;
    logic   valid;
    logic   ready;
    logic   sample_valid;
    logic   touch_detected;
    coord_t touch_x;
    coord_t touch_y;

    modport source (output valid, sample_valid, touch_detected, touch_x, touch_y,
                    input ready);
    modport sink   (input valid, sample_valid, touch_detected, touch_x, touch_y,
                    output ready);
endinterface

FILE: hdl/tpkl_result_if.sv
// ----------------------------------------------------------------------------
// tpkl_result_if
// Result channel: valid/ready handshake with key and PIN status payload.
// ----------------------------------------------------------------------------
interface tpkl_result_if import tpkl_pkg::*;;
    logic               valid;
    logic               ready;
    logic               key_hit;
    key_code_t          key_code;
    logic [COUNT_W-1:0] entered_count;
    logic               pin_accepted;
    logic               pin_rejected;

    modport source (output valid, key_hit, key_code, entered_count, pin_accepted,
                    pin_rejected, input ready);
    modport sink   (input valid, key_hit, key_code, entered_count, pin_accepted,
                    pin_rejected, output ready);
endinterface

FILE: hdl/tpkl_cfg_if.sv
// ----------------------------------------------------------------------------
// tpkl_cfg_if
// Configuration write channel: valid/ready handshake, register index, data.
// ----------------------------------------------------------------------------
interface tpkl_cfg_if import tpkl_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/tpkl_hit_test.sv
// ----------------------------------------------------------------------------
// tpkl_hit_test
// Tests a touch point against the twelve key rectangles, bounds inclusive.
// ----------------------------------------------------------------------------
module tpkl_hit_test import tpkl_pkg::*;
(
    input  coord_t touch_x,
    input  coord_t touch_y,
    input  coord_t origin_x,
    input  coord_t origin_y,
    output key_t   key
);

    span_t x_ext;
    span_t y_ext;
    logic [KEY_COLS-1:0] col_in;
    logic [KEY_ROWS-1:0] row_in;

    assign x_ext = SPAN_W'(touch_x);
    assign y_ext = SPAN_W'(touch_y);

    // Rows and columns are independent ranges; a key is their intersection.
    always_comb
    begin
        span_t left;
        span_t top;
        for (int c = 0; c < KEY_COLS; c++)
        begin
            left = SPAN_W'(origin_x) + COL_OFFSET[c];
            col_in[c] = (x_ext >= left) && (x_ext <= left + KEY_WIDTH);
        end
        for (int r = 0; r < KEY_ROWS; r++)
        begin
            top = SPAN_W'(origin_y) + ROW_OFFSET[r];
            row_in[r] = (y_ext >= top) && (y_ext <= top + KEY_HEIGHT);
        end
    end

    // Rectangles never overlap, so an OR over the hit keys selects one code.
    always_comb
    begin
        key.hit  = 1'b0;
        key.code = '0;
        for (int r = 0; r < KEY_ROWS; r++)
        begin
            for (int c = 0; c < KEY_COLS; c++)
            begin
                if (row_in[r] && col_in[c])
                begin
                    key.hit  = 1'b1;
                    key.code = key.code | KEY_LEGEND[r*KEY_COLS + c];
                end
            end
        end
    end

endmodule

FILE: hdl/tpkl_entry.sv
// ----------------------------------------------------------------------------
// tpkl_entry
// Press edge detection, digit store, and PIN compare. Builds the result for
// the sample in the input register and advances state on step.
// ----------------------------------------------------------------------------
module tpkl_entry import tpkl_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              sample_valid,
    input  logic              touch_detected,
    input  key_t              key,
    input  logic [PIN_W-1:0]  pin_digits,
    input  logic [PLEN_W-1:0] pin_length,
    output result_t           result
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int PEXT_W = (4*MAX_DIGITS > PIN_W) ? 4*MAX_DIGITS : PIN_W;

    logic                press_lock_reg;
    logic                press_lock_next;
    logic [CNT_W-1:0]    digit_count_reg;
    logic [CNT_W-1:0]    digit_count_next;
    key_code_t           digit_store_reg [MAX_DIGITS];

    logic                press;
    logic                match;
    logic                store_wr;
    logic                accept;
    logic                reject;
    logic [PEXT_W-1:0]   pin_ext;
    logic [EXT_W-1:0]    count_ext;

    assign pin_ext = PEXT_W'(pin_digits);
    assign press   = sample_valid && touch_detected && !press_lock_reg;

    // Match: count equals length and every held digit equals its nibble.
    always_comb
    begin
        match = (EXT_W'(digit_count_reg) == EXT_W'(pin_length));
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if ((CNT_W'(i) < digit_count_reg) &&
                (digit_store_reg[i] != pin_ext[4*i +: 4]))
            begin
                match = 1'b0;
            end
        end
    end

    assign accept   = press && key.hit && (key.code == KEY_OK) && match;
    assign reject   = press && key.hit && (key.code == KEY_OK) && !match;
    assign store_wr = press && key.hit && (key.code != KEY_OK) &&
                      (key.code != KEY_CLR) && (digit_count_reg < CNT_W'(MAX_DIGITS));

    always_comb
    begin
        press_lock_next  = press_lock_reg;
        digit_count_next = digit_count_reg;
        if (sample_valid)
        begin
            if (press)
            begin
                press_lock_next = !accept;
            end
            else if (!touch_detected)
            begin
                press_lock_next = 1'b0;
            end
        end
        if (reject || (press && key.hit && (key.code == KEY_CLR)))
        begin
            digit_count_next = '0;
        end
        else if (store_wr)
        begin
            digit_count_next = digit_count_reg + 1'b1;
        end
    end

    assign count_ext            = EXT_W'(digit_count_next);
    assign result.key_hit       = press && key.hit;
    assign result.key_code      = (press && key.hit) ? key.code : '0;
    assign result.entered_count = count_ext[COUNT_W-1:0];
    assign result.pin_accepted  = accept;
    assign result.pin_rejected  = reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_lock_reg  <= 1'b0;
            digit_count_reg <= '0;
        end
        else if (step)
        begin
            press_lock_reg  <= press_lock_next;
            digit_count_reg <= digit_count_next;
        end
    end

    // Entries past the count are never read, so the store needs no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (step && store_wr && (digit_count_reg[IDX_W-1:0] == IDX_W'(i)))
            begin
                digit_store_reg[i] <= key.code;
            end
        end
    end

    a_acc_rej_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && reject))
        else $error("accept and reject in the same sample");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_reject_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && reject |=> digit_count_reg == '0)
        else $error("reject did not clear the entry");

    a_accept_unlocks: assert property (@(posedge clk) disable iff (!rst_n)
        step && accept |=> !press_lock_reg && $stable(digit_count_reg))
        else $error("accept did not release lock or changed the entry");

endmodule

FILE: hdl/touch_pin_keypad_lock.sv
// ----------------------------------------------------------------------------
// touch_pin_keypad_lock
// Touch-panel PIN keypad: one poll sample in, one key/PIN status item out.
// ----------------------------------------------------------------------------
// Usage:
//   sample : touch poll items (sample_valid, touch_detected, touch_x,
//            touch_y) on a valid/ready channel. Every accepted item yields
//            exactly one item on result.
//   result : key_hit, key_code, entered_count, pin_accepted, pin_rejected.
//   cfg    : register writes (index 0 pin_digits, 1 pin_length,
//            2 origin_x, 3 origin_y); always ready. Write only
//            while no item is in flight.
// Throughput: one item per cycle while result is not held off. Each item
//   passes the input register, then the result register; the hit test and
//   7-digit compare sit between the two.
// Stall: when result is held off, the result register holds its item and
//   the input register still takes one more item; sample.ready then drops
//   until result is taken.
// Reset: press lock released, digit entry empty, PIN "1234" of four digits,
//   keypad origin (245, 100). No clearing pass.
// ----------------------------------------------------------------------------
module touch_pin_keypad_lock import tpkl_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  logic  clk,
    input  logic  rst_n,
    tpkl_sample_if.sink   sample,
    tpkl_result_if.source result,
    tpkl_cfg_if.sink      cfg
);

    // Configuration registers
    logic [PIN_W-1:0]  pin_digits_reg;
    logic [PLEN_W-1:0] pin_length_reg;
    coord_t            origin_x_reg;
    coord_t            origin_y_reg;

    // Input register
    logic              in_valid_reg;
    logic              in_sample_valid_reg;
    logic              in_touch_reg;
    coord_t            in_x_reg;
    coord_t            in_y_reg;

    // Result register
    logic              out_valid_reg;
    result_t           out_reg;

    logic              advance;
    key_t              key;
    result_t           result_next;

    // Advance the input item into the result register when that is free.
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    // Hold configuration; the user must write only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_digits_reg <= RST_PIN_DIGITS;
            pin_length_reg <= RST_PIN_LENGTH;
            origin_x_reg   <= RST_ORIGIN_X;
            origin_y_reg   <= RST_ORIGIN_Y;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PIN_DIGITS: pin_digits_reg <= cfg.data[PIN_W-1:0];
                CFG_PIN_LENGTH: pin_length_reg <= cfg.data[PLEN_W-1:0];
                CFG_ORIGIN_X:   origin_x_reg   <= cfg.data[COORD_W-1:0];
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg.data[COORD_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    // Capture the sample payload on accept
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_sample_valid_reg <= sample.sample_valid;
            in_touch_reg        <= sample.touch_detected;
            in_x_reg            <= sample.touch_x;
            in_y_reg            <= sample.touch_y;
        end
    end

    tpkl_hit_test u_hit_test (
        .touch_x  (in_x_reg),
        .touch_y  (in_y_reg),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .key      (key)
    );

    tpkl_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .sample_valid   (in_sample_valid_reg),
        .touch_detected (in_touch_reg),
        .key            (key),
        .pin_digits     (pin_digits_reg),
        .pin_length     (pin_length_reg),
        .result         (result_next)
    );

    // Result register control: drop valid once taken, refill on advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.key_hit       = out_reg.key_hit;
    assign result.key_code      = out_reg.key_code;
    assign result.entered_count = out_reg.entered_count;
    assign result.pin_accepted  = out_reg.pin_accepted;
    assign result.pin_rejected  = out_reg.pin_rejected;

    a_accept_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.pin_accepted || out_reg.pin_rejected) |->
            out_reg.key_hit && (out_reg.key_code == KEY_OK))
        else $error("PIN verdict without an OK key press");

    a_no_code_without_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.key_hit |-> out_reg.key_code == '0)
        else $error("key code set without a key hit");

    a_stall_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule
